/* sv/kec_pkg.sv */
// Keyboard event controller: shared types and constants.
// No dependencies; used by the key cell and the top level.
`default_nettype none
package kec_pkg;

	localparam logic [1:0] ACT_PRESS   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_WRITE   = 2'd2;
	localparam logic [1:0] ACT_COMMAND = 2'd3;

	localparam logic [31:0] CMD_POP   = 32'd1;
	localparam logic [31:0] CMD_RESET = 32'd2;
	localparam logic [31:0] CMD_CHECK = 32'd3;

	localparam logic [31:0] RELEASE_MARK = 32'h0000_8000;
	localparam logic [31:0] EMPTY_PORT   = 32'h0000_FFFF;

	// key event broadcast to every cell
	typedef struct packed {
		logic press;
		logic release_ev;
		logic clear;
	} ev_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic check;
		logic found;
		logic rel;
		logic held;
	} tok_t;

endpackage
`default_nettype wire

/* sv/kec_in_if.sv */
// Keyboard event controller: input item channel (valid/ready plus payload).
// Depends on nothing.
`default_nettype none
interface kec_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  key_code;
	logic [31:0] port_value;
	logic [31:0] command;

	modport source (output valid, action, key_code, port_value, command, input ready);
	modport sink (input valid, action, key_code, port_value, command, output ready);
endinterface
`default_nettype wire

/* sv/kec_out_if.sv */
// Keyboard event controller: result item channel (valid/ready plus payload).
// Depends on nothing.
`default_nettype none
interface kec_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] port_a;
	logic        irq_raise;

	modport source (output valid, port_a, irq_raise, input ready);
	modport sink (input valid, port_a, irq_raise, output ready);
endinterface
`default_nettype wire

/* sv/kec_cell.sv */
// Keyboard event controller: one key cell holding press/release/held flags.
// Depends on kec_pkg; chained by the top level, token registered per cell.
`default_nettype none
module kec_cell #(
	parameter int IW    = 7,
	parameter int INDEX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kec_pkg::ev_t  ev,
	input  wire logic [IW-1:0] ev_idx,
	input  wire kec_pkg::tok_t tok_prev,
	input  wire logic [IW-1:0] idx_prev,
	output kec_pkg::tok_t      tok_next,
	output logic [IW-1:0]      idx_next
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic          press_q;
	logic          rel_q;
	logic          held_q;
	kec_pkg::tok_t tok_q;
	logic [IW-1:0] idx_q;
	logic          mine;
	logic          scan;

	assign mine = (ev_idx == MY_IDX);
	assign scan = tok_prev.valid && !tok_prev.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= 1'b0;
			rel_q   <= 1'b0;
			held_q  <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_prev;
			if (ev.clear) begin
				press_q <= 1'b0;
				rel_q   <= 1'b0;
				held_q  <= 1'b0;
			end else if (ev.press && mine) begin
				press_q <= 1'b1;
				held_q  <= 1'b1;
			end else if (ev.release_ev && mine) begin
				rel_q  <= 1'b1;
				held_q <= 1'b0;
			end else if (scan && !tok_prev.check) begin
				if (rel_q) begin
					rel_q       <= 1'b0;
					press_q     <= 1'b0;
					tok_q.found <= 1'b1;
					tok_q.rel   <= 1'b1;
				end else if (press_q) begin
					press_q     <= 1'b0;
					tok_q.found <= 1'b1;
					tok_q.rel   <= 1'b0;
				end
			end else if (scan && idx_prev == MY_IDX) begin
				tok_q.found <= 1'b1;
				tok_q.held  <= held_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan && !tok_prev.check && (rel_q || press_q))
			idx_q <= MY_IDX;
		else
			idx_q <= idx_prev;
	end

	assign tok_next = tok_q;
	assign idx_next = idx_q;

endmodule
`default_nettype wire

/* sv/keyboard_event_controller_core.sv */
// Keyboard event controller top level: decoder, port register and key cell chain.
// Depends on kec_pkg, kec_in_if, kec_out_if and kec_cell.
//
// Usage:
//   key_ch carries one item per transfer: action, key_code, port_value, command.
//   res_ch returns exactly one result per item: port_a and irq_raise.
//   cfg_we/cfg_wdata write irq_enable; write it only while the block is idle.
// Timing:
//   Key events, port writes, reset, out-of-range checks and unknown commands
//   give a registered result; the next item can be taken in the same cycle
//   as that result is transferred.
//   Pop and in-range check commands send a token down the chain of
//   MAX_KEY_INDEX+1 key cells, one cell per cycle; the token is registered
//   at the chain head and in each cell, and the result when it leaves.
//   key_ch.ready stays low while a token is in the chain.
// Reset:
//   arst_n clears all key flags, sets the port to 0xFFFF and irq_enable to 0.
// Stall:
//   a result not yet taken on res_ch holds key_ch.ready low; nothing is lost.
`default_nettype none
module keyboard_event_controller_core #(
	parameter int MAX_KEY_INDEX = 127
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kec_in_if.sink     key_ch,
	kec_out_if.source  res_ch,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata
);

	localparam int NUM_KEYS = MAX_KEY_INDEX + 1;
	localparam int IW       = (NUM_KEYS > 2) ? $clog2(NUM_KEYS) : 1;
	localparam logic [31:0] MAX_IDX = 32'(MAX_KEY_INDEX);

	kec_pkg::tok_t tok [NUM_KEYS+1];
	logic [IW-1:0] idx [NUM_KEYS+1];

	logic          irq_en_q;
	logic [31:0]   port_q;
	logic          busy_q;
	logic          out_valid_q;
	logic [31:0]   out_port_q;
	logic          out_irq_q;
	kec_pkg::tok_t tok0_q;
	logic [IW-1:0] idx0_q;

	logic          accept;
	logic          key_ok;
	logic [IW-1:0] ev_idx;
	kec_pkg::ev_t  ev;
	logic          start_scan;
	logic          is_check;
	logic [31:0]   imm_port;
	logic          imm_irq;
	logic [31:0]   scan_port;
	kec_pkg::tok_t tok_end;
	logic [IW-1:0] idx_end;

	assign key_ch.ready = !busy_q && (!out_valid_q || res_ch.ready);
	assign accept       = key_ch.valid && key_ch.ready;

	assign key_ok = (key_ch.key_code != 8'd0)
		&& ((32'(key_ch.key_code) - 32'd1) <= MAX_IDX);
	assign ev_idx = IW'(32'(key_ch.key_code) - 32'd1);

	always_comb begin
		ev         = '0;
		start_scan = 1'b0;
		is_check   = 1'b0;
		imm_port   = port_q;
		imm_irq    = 1'b0;
		unique case (key_ch.action)
			kec_pkg::ACT_PRESS: begin
				ev.press = accept && key_ok;
				imm_irq  = key_ok && irq_en_q;
			end
			kec_pkg::ACT_RELEASE: begin
				ev.release_ev = accept && key_ok;
				imm_irq       = key_ok && irq_en_q;
			end
			kec_pkg::ACT_WRITE: begin
				imm_port = key_ch.port_value;
			end
			kec_pkg::ACT_COMMAND: begin
				if (key_ch.command == kec_pkg::CMD_POP) begin
					start_scan = accept;
				end else if (key_ch.command == kec_pkg::CMD_RESET) begin
					ev.clear = accept;
					imm_port = kec_pkg::EMPTY_PORT;
				end else if (key_ch.command == kec_pkg::CMD_CHECK) begin
					if (port_q <= MAX_IDX) begin
						start_scan = accept;
						is_check   = 1'b1;
					end else begin
						imm_port = 32'd0;
					end
				end
			end
			default: ;
		endcase
	end

	assign tok[0] = tok0_q;
	assign idx[0] = idx0_q;

	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
		kec_cell #(
			.IW    (IW),
			.INDEX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ev       (ev),
			.ev_idx   (ev_idx),
			.tok_prev (tok[g]),
			.idx_prev (idx[g]),
			.tok_next (tok[g+1]),
			.idx_next (idx[g+1])
		);
	end

	assign tok_end = tok[NUM_KEYS];
	assign idx_end = idx[NUM_KEYS];

	always_comb begin
		if (tok_end.check)
			scan_port = tok_end.held ? 32'd1 : 32'd0;
		else if (!tok_end.found)
			scan_port = kec_pkg::EMPTY_PORT;
		else if (tok_end.rel)
			scan_port = 32'(idx_end) | kec_pkg::RELEASE_MARK;
		else
			scan_port = 32'(idx_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q    <= 1'b0;
			port_q      <= kec_pkg::EMPTY_PORT;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			tok0_q      <= '0;
		end else begin
			if (cfg_we)
				irq_en_q <= cfg_wdata;
			tok0_q <= '0;
			if (out_valid_q && res_ch.ready)
				out_valid_q <= 1'b0;
			if (start_scan) begin
				busy_q       <= 1'b1;
				tok0_q.valid <= 1'b1;
				tok0_q.check <= is_check;
			end else if (accept) begin
				port_q      <= imm_port;
				out_valid_q <= 1'b1;
			end
			if (tok_end.valid) begin
				busy_q      <= 1'b0;
				port_q      <= scan_port;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx0_q <= IW'(port_q);
		if (tok_end.valid) begin
			out_port_q <= scan_port;
			out_irq_q  <= 1'b0;
		end else if (accept && !start_scan) begin
			out_port_q <= imm_port;
			out_irq_q  <= imm_irq;
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.port_a    = out_port_q;
	assign res_ch.irq_raise = out_irq_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !key_ch.ready)
		else $error("item taken while a scan is in the chain");

	a_scan_injects_token: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> tok0_q.valid)
		else $error("scan started without a token at the head of the chain");

	a_token_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.valid |-> busy_q)
		else $error("token left the chain with no scan in progress");

	a_scan_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_valid_q)
		else $error("scan finished without a result");

endmodule
`default_nettype wire
